// File: hw/rtl/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer
// field widths, operation and register codes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    // fixed field widths of the command and result words
    localparam int OPCODE_W       = 2;
    localparam int CHAR_W         = 8;
    localparam int COL_FIELD_W    = 7;
    localparam int ROW_FIELD_W    = 5;
    localparam int CELL_W         = 16;
    localparam int CURSOR_INDEX_W = 11;
    localparam int COLOR_W        = 4;
    localparam int CFG_INDEX_W    = 2;

    // character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_GOTO  = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_CLEAR,
        ST_FINISH
    } state_t;

endpackage

// File: hw/rtl/text_console_writer_core.sv
// text_console_writer_core: top level of the text console writer
// sequencer, cursor, colour registers and result word register
// depends on tcw_pkg, tcw_addr_unit and tcw_cell_mem
`timescale 1ns / 1ps

// Usage: a command word (opcode, char_code, col, row) is taken at a rising
// edge with start high and busy low. busy stays high until the command is
// finished. Each command gives one result word, shown for exactly one cycle
// with done high; the receiver cannot hold it off, and a new command may be
// taken in the same cycle that done is high.
// Sequencer steps from accept to done, by command:
//   put, goto, off-screen read, newline without scroll: execute, finish
//   read cell: execute, read wait (the cell store read is registered), finish
//   put or newline that scrolls: execute, scroll, finish; one cell copied a cycle
//   clear: execute, clear, finish; one blank cell written a cycle
// The scroll and clear sweeps go through the single write port of the cell
// store; the scroll read address comes from the shared address unit.
// Colour registers are written on cfg_write at any edge, meant while idle.
// Reset clears cursor, colours and sequencer; the cell store is not cleared
// and holds unknown cells until a clear command or puts have written them.

module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [tcw_pkg::OPCODE_W-1:0]         opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]           char_code,
    input  logic [tcw_pkg::COL_FIELD_W-1:0]      col,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0]      row,
    output logic                                 done,
    output logic [tcw_pkg::CELL_W-1:0]           cell_value,
    output logic [tcw_pkg::COL_FIELD_W-1:0]      cursor_col,
    output logic [tcw_pkg::ROW_FIELD_W-1:0]      cursor_row,
    output logic [tcw_pkg::CURSOR_INDEX_W-1:0]   cursor_index,
    input  logic                                 cfg_write,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]          cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] CLEAR_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);

    state_t                  state_reg, state_next;
    logic [COLOR_W-1:0]      fg_reg, bg_reg;
    logic [COL_W-1:0]        cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]        cur_line_reg, cur_line_next;
    logic [ADDR_W-1:0]       sweep_reg, sweep_next;
    logic [CELL_W-1:0]       cell_reg, cell_next;
    opcode_t                 op_reg;
    logic [CHAR_W-1:0]       char_reg;
    logic [COL_FIELD_W-1:0]  col_reg;
    logic [ROW_FIELD_W-1:0]  row_reg;

    logic                    done_reg;
    logic [CELL_W-1:0]       cell_value_reg;
    logic [COL_FIELD_W-1:0]  cursor_col_reg;
    logic [ROW_FIELD_W-1:0]  cursor_row_reg;
    logic [CURSOR_INDEX_W-1:0] cursor_index_reg;

    logic                    accept;
    logic [ROW_W-1:0]        au_line;
    logic [ADDR_W-1:0]       au_offset;
    logic [ADDR_W-1:0]       au_sum;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [CELL_W-1:0]       mem_wdata, mem_rdata;
    logic                    is_newline, at_last_col, wrap, read_in_range;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    assign is_newline    = (char_reg == NEWLINE_CODE);
    assign at_last_col   = (cur_col_reg == COL_LAST);
    assign wrap          = is_newline || at_last_col;
    assign read_in_range = (int'(col_reg) < COLUMNS) && (int'(row_reg) < ROWS);

    // shared address unit
    tcw_addr_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_addr_unit (
        .line   (au_line),
        .offset (au_offset),
        .sum    (au_sum)
    );

    // screen cell store
    tcw_cell_mem #(
        .DEPTH (CELLS)
    ) u_cell_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // colour registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= '0;
            bg_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_FOREGROUND)
            begin
                fg_reg <= cfg_data;
            end
            else if (cfg_index == CFG_BACKGROUND)
            begin
                bg_reg <= cfg_data;
            end
        end
    end

    // command word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode_t'(opcode);
            char_reg <= char_code;
            col_reg  <= col;
            row_reg  <= row;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_PUT:
                    begin
                        if (wrap && (cur_line_reg == ROW_LAST))
                        begin
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_GOTO:  state_next = ST_FINISH;
                    OP_READ:  state_next = read_in_range ? ST_READ_WAIT : ST_FINISH;
                    default:  state_next = ST_FINISH;
                endcase
            end
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_SCROLL:
            begin
                if (sweep_reg == SCROLL_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CLEAR:
            begin
                if (sweep_reg == CLEAR_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath controls and cursor update
    always_comb
    begin
        cur_col_next  = cur_col_reg;
        cur_line_next = cur_line_reg;
        sweep_next    = sweep_reg;
        cell_next     = cell_reg;
        au_line       = cur_line_reg;
        au_offset     = ADDR_W'(cur_col_reg);
        mem_we        = 1'b0;
        mem_waddr     = au_sum;
        mem_wdata     = {fg_reg, bg_reg, char_reg} ;
        mem_re        = 1'b0;
        mem_raddr     = au_sum;
        unique case (state_reg)
            ST_EXEC:
            begin
                cell_next  = '0;
                sweep_next = '0;
                unique case (op_reg)
                    OP_PUT:
                    begin
                        mem_we    = !is_newline;
                        mem_wdata = {bg_reg, fg_reg, char_reg};
                        if (wrap)
                        begin
                            cur_col_next = '0;
                            if (cur_line_reg != ROW_LAST)
                            begin
                                cur_line_next = cur_line_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            cur_col_next = cur_col_reg + 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cur_col_next  = '0;
                        cur_line_next = '0;
                    end
                    OP_GOTO:
                    begin
                        cur_col_next  = (int'(col_reg) < COLUMNS) ? COL_W'(col_reg) : COL_LAST;
                        cur_line_next = (int'(row_reg) < ROWS) ? ROW_W'(row_reg) : ROW_LAST;
                    end
                    OP_READ:
                    begin
                        au_line   = ROW_W'(row_reg);
                        au_offset = ADDR_W'(col_reg);
                        mem_re    = read_in_range;
                    end
                    default:
                    begin
                        cell_next = '0;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                cell_next = mem_rdata;
            end
            ST_SCROLL:
            begin
                // read one row down, write the previous source one row up
                au_line    = ROW_W'(1);
                au_offset  = sweep_reg;
                mem_re     = (sweep_reg != SCROLL_LAST);
                mem_raddr  = au_sum;
                mem_we     = (sweep_reg != '0);
                mem_waddr  = sweep_reg - 1'b1;
                mem_wdata  = mem_rdata;
                sweep_next = sweep_reg + 1'b1;
            end
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = {bg_reg, {COLOR_W{1'b0}}, SPACE_CODE};
                sweep_next = sweep_reg + 1'b1;
            end
            default:
            begin
                sweep_next = sweep_reg;
            end
        endcase
    end

    // sequencer and cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_col_reg  <= '0;
            cur_line_reg <= '0;
            sweep_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_col_reg  <= cur_col_next;
            cur_line_reg <= cur_line_next;
            sweep_reg    <= sweep_next;
        end
    end

    // cell value of the pending result word
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    // result word register, one cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_FINISH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH)
        begin
            cell_value_reg   <= cell_reg;
            cursor_col_reg   <= COL_FIELD_W'(cur_col_reg);
            cursor_row_reg   <= ROW_FIELD_W'(cur_line_reg);
            cursor_index_reg <= CURSOR_INDEX_W'(au_sum);
        end
    end

    assign done         = done_reg;
    assign cell_value   = cell_value_reg;
    assign cursor_col   = cursor_col_reg;
    assign cursor_row   = cursor_row_reg;
    assign cursor_index = cursor_index_reg;

`ifndef SYNTH
    // a result word only follows the finishing step
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH))
        else $error("result word without finishing step");

    // an accepted command always makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command accepted but block not busy");

    // the cell store is never written while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !mem_we)
        else $error("cell store written while idle");

    // the cursor stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_col_reg) < COLUMNS) && (int'(cur_line_reg) < ROWS))
        else $error("cursor off screen");
`endif

endmodule

// File: hw/rtl/tcw_addr_unit.sv
// tcw_addr_unit: shared linear address unit, line * COLUMNS + offset
// used for cell writes, cell reads, scroll source and cursor index
// depends on nothing but its parameters
`timescale 1ns / 1ps

module tcw_addr_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic [$clog2(ROWS)-1:0]          line,
    input  logic [$clog2(COLUMNS*ROWS)-1:0]  offset,
    output logic [$clog2(COLUMNS*ROWS)-1:0]  sum
);

    localparam int ADDR_W = $clog2(COLUMNS * ROWS);
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

    // constant multiply and add
    assign sum = ADDR_W'(line) * COLS_A + offset;

endmodule

// File: hw/rtl/tcw_cell_mem.sv
// tcw_cell_mem: screen cell store, one write and one registered read a cycle
// contents are undefined until written
// uses tcw_pkg for the cell width
`timescale 1ns / 1ps

module tcw_cell_mem #(
    parameter int DEPTH = 2000
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]       wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]       rd_data
);

    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: tb/sv/tb_text_console_writer_core.sv
`timescale 1ns / 1ps
// tb_text_console_writer_core: self-checking testbench of the text console writer
// sends command words, predicts every result word and checks it when done is seen
// depends on tcw_pkg and text_console_writer_core

module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELLS         = COLUMNS * ROWS;
    localparam int SCROLL_BUDGET = 30;
    localparam int CLEAR_BUDGET  = 5;
    localparam int PHASE_WORDS   = 400;

    // register indexes that select no register
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [CELL_W-1:0]         cval;
        logic [COL_FIELD_W-1:0]    ccol;
        logic [ROW_FIELD_W-1:0]    crow;
        logic [CURSOR_INDEX_W-1:0] cidx;
    } console_result_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    logic                      busy;
    logic [OPCODE_W-1:0]       opcode    = '0;
    logic [CHAR_W-1:0]         char_code = '0;
    logic [COL_FIELD_W-1:0]    col       = '0;
    logic [ROW_FIELD_W-1:0]    row       = '0;
    logic                      done;
    logic [CELL_W-1:0]         cell_value;
    logic [COL_FIELD_W-1:0]    cursor_col;
    logic [ROW_FIELD_W-1:0]    cursor_row;
    logic [CURSOR_INDEX_W-1:0] cursor_index;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [COLOR_W-1:0]        cfg_data  = '0;

    // predicted screen, cursor and colours
    logic [CELL_W-1:0]  screen_image [CELLS];
    int unsigned        cursor_x;
    int unsigned        cursor_y;
    logic [COLOR_W-1:0] fg_colour;
    logic [COLOR_W-1:0] bg_colour;

    console_result_t    expected_words [$];
    int                 error_count;
    int                 sender_idle_pct;
    int                 scrolls_left;
    int                 clears_left;

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .char_code    (char_code),
        .col          (col),
        .row          (row),
        .done         (done),
        .cell_value   (cell_value),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .cursor_index (cursor_index),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // console behaviour for one command word, returns the result word
    function automatic console_result_t console_step(input opcode_t op,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input logic [COL_FIELD_W-1:0] c,
                                                     input logic [ROW_FIELD_W-1:0] r);
        console_result_t res;
        logic            wrap;
        int              i;
        res.cval = '0;
        wrap     = 1'b0;
        case (op)
            OP_PUT:
            begin
                if (ch != NEWLINE_CODE)
                begin
                    screen_image[cursor_y * COLUMNS + cursor_x] = {bg_colour, fg_colour, ch};
                    cursor_x++;
                    if (cursor_x >= COLUMNS)
                        wrap = 1'b1;
                end
                else
                    wrap = 1'b1;
                if (wrap)
                begin
                    cursor_x = 0;
                    cursor_y++;
                    // off the bottom: move every row up, bottom row kept
                    if (cursor_y >= ROWS)
                    begin
                        for (i = 0; i < CELLS - COLUMNS; i++)
                            screen_image[i] = screen_image[i + COLUMNS];
                        cursor_y = ROWS - 1;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_image[i] = {bg_colour, 4'h0, SPACE_CODE};
                cursor_x = 0;
                cursor_y = 0;
            end
            OP_GOTO:
            begin
                cursor_x = (c < COLUMNS) ? c : COLUMNS - 1;
                cursor_y = (r < ROWS) ? r : ROWS - 1;
            end
            default:
            begin
                if (c < COLUMNS && r < ROWS)
                    res.cval = screen_image[r * COLUMNS + c];
            end
        endcase
        res.ccol = COL_FIELD_W'(cursor_x);
        res.crow = ROW_FIELD_W'(cursor_y);
        res.cidx = CURSOR_INDEX_W'(cursor_y * COLUMNS + cursor_x);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [CELL_W-1:0] got,
                                   input logic [CELL_W-1:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // send one command word, predict its result once the block is no longer busy
    task automatic send_command(input opcode_t op, input logic [CHAR_W-1:0] ch,
                                input logic [COL_FIELD_W-1:0] c,
                                input logic [ROW_FIELD_W-1:0] r);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        char_code <= ch;
        col       <= c;
        row       <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_words.push_back(console_step(op, ch, c, r));
    endtask

    // stop sending and wait for every outstanding result word
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // colour registers, written only while the block is idle
    task automatic program_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                                   input bit touch_unused);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= CFG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge clk);
        if (touch_unused)
        begin
            cfg_index <= CFG_UNUSED_A;
            cfg_data  <= COLOR_W'($urandom_range(15));
            @(posedge clk);
            cfg_index <= CFG_UNUSED_B;
            cfg_data  <= COLOR_W'($urandom_range(15));
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
        fg_colour = fg;
        bg_colour = bg;
    endtask

    // result word check against the oldest prediction
    always @(posedge clk)
    begin : check_results
        console_result_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
                report_mismatch("result word with nothing outstanding", cell_value, '0);
            else
            begin
                want = expected_words.pop_front();
                if (cell_value !== want.cval)
                    report_mismatch("cell_value", cell_value, want.cval);
                if (cursor_col !== want.ccol)
                    report_mismatch("cursor_col", CELL_W'(cursor_col), CELL_W'(want.ccol));
                if (cursor_row !== want.crow)
                    report_mismatch("cursor_row", CELL_W'(cursor_row), CELL_W'(want.crow));
                if (cursor_index !== want.cidx)
                    report_mismatch("cursor_index", CELL_W'(cursor_index), CELL_W'(want.cidx));
            end
        end
    end

    // first command: clear, so that no cell is read before it is defined
    task automatic test_clear_after_reset();
        send_command(OP_CLEAR, 8'h00, 7'd0, 5'd0);
        send_command(OP_READ, 8'hFF, 7'd0, 5'd0);
    endtask

    // extreme character codes, newline stores nothing
    task automatic test_put_and_newline();
        program_colours(4'hF, 4'h0, 1'b0);
        send_command(OP_PUT, 8'h00, 7'd127, 5'd31);
        send_command(OP_PUT, 8'hFF, 7'd0, 5'd0);
        send_command(OP_PUT, NEWLINE_CODE, 7'd5, 5'd5);
        send_command(OP_READ, 8'h00, 7'd0, 5'd0);
        send_command(OP_READ, 8'h00, 7'd1, 5'd0);
        send_command(OP_READ, 8'h00, 7'd2, 5'd0);
        send_command(OP_READ, 8'h00, 7'd0, 5'd1);
    endtask

    // goto saturation and reads outside the screen
    task automatic test_goto_and_read_limits();
        send_command(OP_GOTO, 8'h00, 7'd127, 5'd31);
        send_command(OP_READ, 8'h00, 7'd80, 5'd0);
        send_command(OP_READ, 8'h00, 7'd0, 5'd25);
        send_command(OP_READ, 8'h00, 7'd127, 5'd31);
        send_command(OP_READ, 8'h00, 7'd79, 5'd24);
        send_command(OP_GOTO, 8'h00, 7'd0, 5'd0);
    endtask

    // last-column wrap, scroll by put and by newline on the bottom row
    task automatic test_wrap_and_scroll();
        send_command(OP_GOTO, 8'h00, 7'd79, 5'd23);
        send_command(OP_PUT, 8'h78, 7'd0, 5'd0);
        send_command(OP_GOTO, 8'h00, 7'd79, 5'd24);
        send_command(OP_PUT, 8'h7A, 7'd0, 5'd0);
        send_command(OP_PUT, NEWLINE_CODE, 7'd0, 5'd0);
        send_command(OP_READ, 8'h00, 7'd79, 5'd21);
        send_command(OP_READ, 8'h00, 7'd79, 5'd23);
    endtask

    // full-scale colours in written and blank cells, unused indexes ignored
    task automatic test_colour_registers();
        program_colours(4'hF, 4'hF, 1'b1);
        send_command(OP_CLEAR, 8'h55, 7'd64, 5'd16);
        send_command(OP_PUT, 8'hA5, 7'd0, 5'd0);
        send_command(OP_READ, 8'h00, 7'd0, 5'd0);
        send_command(OP_READ, 8'h00, 7'd40, 5'd12);
    endtask

    // one phase of random traffic: lines of text, reads, gotos, rare clears
    task automatic run_traffic_phase(input int idle_pct, input int words);
        int unsigned            kind;
        int unsigned            run_len;
        int unsigned            k;
        int                     issued;
        bit                     scrolls;
        logic [CHAR_W-1:0]      ch;
        logic [COL_FIELD_W-1:0] c;
        logic [ROW_FIELD_W-1:0] r;
        sender_idle_pct = idle_pct;
        scrolls_left    = SCROLL_BUDGET;
        clears_left     = CLEAR_BUDGET;
        issued          = 0;
        while (issued < words)
        begin
            kind = $urandom_range(99);
            ch   = CHAR_W'($urandom_range(255));
            c    = COL_FIELD_W'($urandom_range(127));
            r    = ROW_FIELD_W'($urandom_range(31));
            if (kind < 60)
            begin
                // a run of characters with the odd newline
                run_len = $urandom_range(1, 24);
                for (k = 0; k < run_len; k++)
                begin
                    ch = ($urandom_range(15) == 0) ? NEWLINE_CODE
                                                   : CHAR_W'($urandom_range(255));
                    scrolls = (cursor_y == ROWS - 1) &&
                              (ch == NEWLINE_CODE || cursor_x == COLUMNS - 1);
                    // scrolls are slow, so once the budget is spent move up instead
                    if (scrolls && scrolls_left == 0)
                        send_command(OP_GOTO, ch, COL_FIELD_W'($urandom_range(COLUMNS - 1)),
                                     ROW_FIELD_W'($urandom_range(ROWS - 2)));
                    else
                    begin
                        if (scrolls)
                            scrolls_left--;
                        send_command(OP_PUT, ch, COL_FIELD_W'($urandom_range(127)),
                                     ROW_FIELD_W'($urandom_range(31)));
                    end
                    issued++;
                end
            end
            else if (kind < 80)
            begin
                // mostly the cell just written, sometimes anywhere, even off screen
                if ($urandom_range(2) != 0 && cursor_x > 0)
                begin
                    c = COL_FIELD_W'(cursor_x - 1);
                    r = ROW_FIELD_W'(cursor_y);
                end
                else if ($urandom_range(3) != 0)
                begin
                    c = COL_FIELD_W'($urandom_range(COLUMNS - 1));
                    r = ROW_FIELD_W'($urandom_range(ROWS - 1));
                end
                send_command(OP_READ, ch, c, r);
                issued++;
            end
            else if (kind < 97)
            begin
                // goto, often near the bottom so that scrolls come up
                if ($urandom_range(3) != 0)
                begin
                    c = COL_FIELD_W'($urandom_range(COLUMNS - 1));
                    r = ($urandom_range(1) == 0) ? ROW_FIELD_W'($urandom_range(ROWS - 3, ROWS - 1))
                                                 : ROW_FIELD_W'($urandom_range(ROWS - 1));
                end
                send_command(OP_GOTO, ch, c, r);
                issued++;
            end
            else
            begin
                if (clears_left > 0)
                begin
                    clears_left--;
                    send_command(OP_CLEAR, ch, c, r);
                end
                else
                    send_command(OP_READ, ch, c, r);
                issued++;
            end
        end
    endtask

    // three phases with different sender idling and colour settings
    task automatic test_random_traffic();
        program_colours(4'hF, 4'h0, 1'b0);
        run_traffic_phase(26, PHASE_WORDS);
        program_colours(4'h0, 4'hF, 1'b1);
        run_traffic_phase(53, PHASE_WORDS);
        program_colours(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)), 1'b0);
        run_traffic_phase(0, PHASE_WORDS);
    endtask

    initial
    begin
        error_count     = 0;
        cursor_x        = 0;
        cursor_y        = 0;
        fg_colour       = '0;
        bg_colour       = '0;
        sender_idle_pct = 26;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clear_after_reset();
        test_put_and_newline();
        test_goto_and_read_limits();
        test_wrap_and_scroll();
        test_colour_registers();
        test_random_traffic();

        // drain, then watch for stray result words over a full sweep
        wait_idle();
        repeat (CELLS + 16) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
